// ===== rtl/ppc_pkg.sv =====
package ppc_pkg;

    // Block configuration
    localparam int CHANNELS = 3;
    localparam int MAX_STEP = 12;

    // Field widths
    localparam int CH_W      = 2;
    localparam int MV_W      = 12;
    localparam int CAL_W     = 13;
    localparam int DZ_W      = 6;
    localparam int POS_W     = 8;
    localparam int AVG_W     = 16;
    localparam int NCH_REGS  = 3;
    localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_CH0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_CH0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_CH1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_CH1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_CH2   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_CH2  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE = 3'd6;

    localparam logic [CAL_W-1:0] LOW_RESET  = 13'd5000;
    localparam logic [CAL_W-1:0] HIGH_RESET = 13'd0;
    localparam logic [DZ_W-1:0]  DZ_RESET   = 6'd5;
    localparam logic [DZ_W-1:0]  DZ_MAX     = 6'd45;

    // Shared multiplier
    localparam int MUL_W  = 20;
    localparam int PROD_W = 2 * MUL_W;

    // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT, exact for x < 493447
    localparam int TRIM_IN_W   = 19;
    localparam int RECIP_SHIFT = 25;
    localparam logic [TRIM_IN_W-1:0] RECIP_100 = 19'd335545;

    // Divider: quotient is at most 255, so QUOT_W restoring steps
    localparam int QUOT_W = POS_W;
    localparam int NUM_W  = CAL_W + QUOT_W;
    localparam int CNT_W  = $clog2(QUOT_W);

    // Smoother arithmetic
    localparam int DELTA_W   = AVG_W + 1;
    localparam int EPROD_W   = 26;
    localparam int AVG_SUM_W = AVG_W + 2;
    localparam int DIFF_W    = POS_W + 2;
    localparam int ALPHA_W   = 8;

    localparam logic [ALPHA_W-1:0]            ALPHA_FAST  = 8'd179;
    localparam logic [ALPHA_W-1:0]            ALPHA_SLOW  = 8'd51;
    localparam logic signed [DELTA_W-1:0]     FAST_THRESH = 17'sd4096;
    localparam logic signed [EPROD_W-1:0]     ROUND_HALF  = 26'sd128;
    localparam logic [AVG_W-1:0]              AVG_MAX     = 16'd65280;
    localparam logic [AVG_W-1:0]              AVG_HALF    = 16'd128;
    localparam logic signed [DIFF_W-1:0]      STEP_MAX_S  = DIFF_W'(MAX_STEP);
    localparam logic signed [DIFF_W-1:0]      DEAD_BAND   = 10'sd2;
    localparam logic signed [DIFF_W-1:0]      POS_MAX_S   = 10'sd255;

    // Sequencer
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SPAN,
        ST_TRIM,
        ST_RANGE,
        ST_CLAMP,
        ST_DIVGO,
        ST_DIV,
        ST_EMA,
        ST_AVG,
        ST_POS,
        ST_DONE
    } t_state;

    // Divider handshake
    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

endpackage

// ===== rtl/ppc_if.sv =====
interface ppc_in_if;
    logic                       valid;
    logic                       ready;
    logic [ppc_pkg::CH_W-1:0]   channel;
    logic [ppc_pkg::MV_W-1:0]   sample_mv;

    modport source (output valid, channel, sample_mv, input ready);
    modport sink   (input valid, channel, sample_mv, output ready);
endinterface

interface ppc_out_if;
    logic                       valid;
    logic                       ready;
    logic [ppc_pkg::POS_W-1:0]  position;

    modport source (output valid, position, input ready);
    modport sink   (input valid, position, output ready);
endinterface

interface ppc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ppc_pkg::CFG_IDX_W-1:0]   index;
    logic [ppc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/ppc_mul.sv =====
module ppc_mul (
    input  logic                               i_clk,
    input  logic signed [ppc_pkg::MUL_W-1:0]   i_a,
    input  logic signed [ppc_pkg::MUL_W-1:0]   i_b,
    output logic signed [ppc_pkg::PROD_W-1:0]  o_prod
);

    logic signed [ppc_pkg::PROD_W-1:0] r_prod;

    // Signed multiply, product registered
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/ppc_div.sv =====
module ppc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ppc_pkg::NUM_W-1:0]     i_num,
    input  logic [ppc_pkg::CAL_W-1:0]     i_den,
    output ppc_pkg::t_div_rsp             o_rsp
);

    logic                         r_busy;
    logic                         r_done;
    logic [ppc_pkg::CNT_W-1:0]    r_cnt;
    logic [ppc_pkg::NUM_W-1:0]    r_rem;
    logic [ppc_pkg::NUM_W-1:0]    r_dsh;
    logic [ppc_pkg::QUOT_W-1:0]   r_quot;
    logic                         w_fit;

    assign w_fit = (r_rem >= r_dsh);

    // Step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ppc_pkg::CNT_W'(ppc_pkg::QUOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Restoring division, one quotient bit per cycle, MSB first
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_dsh  <= ppc_pkg::NUM_W'(i_den) << (ppc_pkg::QUOT_W - 1);
            r_quot <= '0;
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem <= r_rem - r_dsh;
            end
            r_quot <= {r_quot[ppc_pkg::QUOT_W-2:0], w_fit};
            r_dsh  <= r_dsh >> 1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// ===== rtl/pedal_position_conditioner_unit.sv =====
// Channel  Dir  Beat carries              Handshake
// i_in     in   channel, sample_mv        valid/ready
// o_out    out  position                  valid/ready
// i_cfg    in   index, data               valid/ready (ready always high)
//
// The sequencer carries a beat from acceptance to a loaded result, walking the shared
// multiplier three times and the 8-step divider; the first sample of a channel skips
// the average and position states. An uncalibrated or out-of-range channel goes
// from lookup straight to done and loads a zero result.
// i_in is ready only in the idle state; a result waits in the output register
// and a finished item holds in the done state until that register frees up.
// Synchronous active-low reset restores register defaults and clears all
// per-channel smoother state.
module pedal_position_conditioner_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ppc_in_if.sink     i_in,
    ppc_out_if.source  o_out,
    ppc_cfg_if.sink    i_cfg
);

    ppc_pkg::t_state r_state;
    ppc_pkg::t_state n_state;

    // Configuration registers
    logic [ppc_pkg::CAL_W-1:0]  r_low  [ppc_pkg::NCH_REGS];
    logic [ppc_pkg::CAL_W-1:0]  r_high [ppc_pkg::NCH_REGS];
    logic [ppc_pkg::DZ_W-1:0]   r_dz;

    // Per-channel smoother state
    logic                       r_seeded [ppc_pkg::CHANNELS];
    logic [ppc_pkg::AVG_W-1:0]  r_avg    [ppc_pkg::CHANNELS];
    logic [ppc_pkg::POS_W-1:0]  r_last   [ppc_pkg::CHANNELS];

    // Working registers
    logic [ppc_pkg::CH_W-1:0]   r_ch;
    logic [ppc_pkg::MV_W-1:0]   r_mv;
    logic [ppc_pkg::CAL_W-1:0]  r_lo;
    logic [ppc_pkg::CAL_W-1:0]  r_hi;
    logic [ppc_pkg::CAL_W-1:0]  r_span;
    logic [ppc_pkg::CAL_W-1:0]  r_rlo;
    logic [ppc_pkg::CAL_W-1:0]  r_rhi;
    logic [ppc_pkg::CAL_W-1:0]  r_rspan;
    logic [ppc_pkg::NUM_W-1:0]  r_num;
    logic [ppc_pkg::POS_W-1:0]  r_scaled;
    logic [ppc_pkg::POS_W-1:0]  r_res;
    logic                       r_out_valid;
    logic [ppc_pkg::POS_W-1:0]  r_out_pos;

    // Shared units
    logic signed [ppc_pkg::MUL_W-1:0]   w_mul_a;
    logic signed [ppc_pkg::MUL_W-1:0]   w_mul_b;
    logic signed [ppc_pkg::PROD_W-1:0]  w_prod;
    logic                               w_div_start;
    ppc_pkg::t_div_rsp                  w_div;

    // Combinational datapath
    logic [ppc_pkg::CH_IDX_W-1:0]       w_ci;
    logic [ppc_pkg::CAL_W-1:0]          w_lo;
    logic [ppc_pkg::CAL_W-1:0]          w_hi;
    logic                               w_skip;
    logic [ppc_pkg::DZ_W-1:0]           w_dz_sat;
    logic [ppc_pkg::CAL_W-1:0]          w_trim;
    logic [ppc_pkg::CAL_W-1:0]          w_mv_ext;
    logic [ppc_pkg::CAL_W-1:0]          w_v;
    logic [ppc_pkg::CAL_W-1:0]          w_off;
    logic signed [ppc_pkg::DELTA_W-1:0] w_delta;
    logic                               w_fast;
    logic [ppc_pkg::ALPHA_W-1:0]        w_alpha;
    logic signed [ppc_pkg::EPROD_W-1:0] w_rnd;
    logic signed [ppc_pkg::AVG_SUM_W-1:0] w_inc;
    logic signed [ppc_pkg::AVG_SUM_W-1:0] w_avg_sum;
    logic [ppc_pkg::AVG_W-1:0]          w_avg_new;
    logic [ppc_pkg::AVG_W-1:0]          w_avg_half;
    logic [ppc_pkg::POS_W-1:0]          w_rounded;
    logic signed [ppc_pkg::DIFF_W-1:0]  w_last_s;
    logic signed [ppc_pkg::DIFF_W-1:0]  w_diff;
    logic signed [ppc_pkg::DIFF_W-1:0]  w_step;
    logic signed [ppc_pkg::DIFF_W-1:0]  w_pos_sum;
    logic [ppc_pkg::POS_W-1:0]          w_pos_new;

    ppc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    ppc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num),
        .i_den   (r_rspan),
        .o_rsp   (w_div)
    );

    // Calibration lookup and skip test
    assign w_ci = r_ch[ppc_pkg::CH_IDX_W-1:0];
    always_comb begin
        w_lo = '0;
        w_hi = '0;
        if (r_ch < ppc_pkg::CH_W'(ppc_pkg::NCH_REGS)) begin
            w_lo = r_low[r_ch];
            w_hi = r_high[r_ch];
        end
    end
    assign w_skip = (r_ch >= ppc_pkg::CH_W'(ppc_pkg::CHANNELS)) || (w_hi <= w_lo);

    assign w_dz_sat = (r_dz > ppc_pkg::DZ_MAX) ? ppc_pkg::DZ_MAX : r_dz;

    // trim = floor(span * dz / 100) from the reciprocal product
    assign w_trim = w_prod[ppc_pkg::RECIP_SHIFT +: ppc_pkg::CAL_W];

    // Clamp sample into trimmed range
    assign w_mv_ext = ppc_pkg::CAL_W'(r_mv);
    assign w_v   = (w_mv_ext < r_rlo) ? r_rlo : ((w_mv_ext > r_rhi) ? r_rhi : w_mv_ext);
    assign w_off = w_v - r_rlo;

    // EMA error and alpha pick
    assign w_delta = $signed({1'b0, r_scaled, 8'b0}) - $signed({1'b0, r_avg[w_ci]});
    assign w_fast  = (w_delta >= ppc_pkg::FAST_THRESH) || (w_delta <= -ppc_pkg::FAST_THRESH);
    assign w_alpha = w_fast ? ppc_pkg::ALPHA_FAST : ppc_pkg::ALPHA_SLOW;

    // Rounded Q8.8 increment, average clamp
    assign w_rnd     = $signed(w_prod[ppc_pkg::EPROD_W-1:0]) + ppc_pkg::ROUND_HALF;
    assign w_inc     = ppc_pkg::AVG_SUM_W'(w_rnd >>> 8);
    assign w_avg_sum = $signed({2'b00, r_avg[w_ci]}) + w_inc;
    always_comb begin
        if (w_avg_sum < 0) begin
            w_avg_new = '0;
        end else if (w_avg_sum > $signed({2'b00, ppc_pkg::AVG_MAX})) begin
            w_avg_new = ppc_pkg::AVG_MAX;
        end else begin
            w_avg_new = w_avg_sum[ppc_pkg::AVG_W-1:0];
        end
    end

    // Dead band and slew limit on the output
    assign w_avg_half = r_avg[w_ci] + ppc_pkg::AVG_HALF;
    assign w_rounded  = w_avg_half[ppc_pkg::AVG_W-1:8];
    assign w_last_s   = $signed({2'b00, r_last[w_ci]});
    assign w_diff     = $signed({2'b00, w_rounded}) - w_last_s;
    always_comb begin
        if (w_diff > ppc_pkg::STEP_MAX_S) begin
            w_step = ppc_pkg::STEP_MAX_S;
        end else if (w_diff < -ppc_pkg::STEP_MAX_S) begin
            w_step = -ppc_pkg::STEP_MAX_S;
        end else begin
            w_step = w_diff;
        end
    end
    assign w_pos_sum = w_last_s + w_step;
    always_comb begin
        if ((w_diff < ppc_pkg::DEAD_BAND) && (w_diff > -ppc_pkg::DEAD_BAND)) begin
            w_pos_new = r_last[w_ci];
        end else if (w_pos_sum < 0) begin
            w_pos_new = '0;
        end else if (w_pos_sum > ppc_pkg::POS_MAX_S) begin
            w_pos_new = ppc_pkg::POS_MAX_S[ppc_pkg::POS_W-1:0];
        end else begin
            w_pos_new = w_pos_sum[ppc_pkg::POS_W-1:0];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ppc_pkg::ST_IDLE:   if (i_in.valid) n_state = ppc_pkg::ST_LOOKUP;
            ppc_pkg::ST_LOOKUP: n_state = w_skip ? ppc_pkg::ST_DONE : ppc_pkg::ST_SPAN;
            ppc_pkg::ST_SPAN:   n_state = ppc_pkg::ST_TRIM;
            ppc_pkg::ST_TRIM:   n_state = ppc_pkg::ST_RANGE;
            ppc_pkg::ST_RANGE:  n_state = ppc_pkg::ST_CLAMP;
            ppc_pkg::ST_CLAMP:  n_state = ppc_pkg::ST_DIVGO;
            ppc_pkg::ST_DIVGO:  n_state = ppc_pkg::ST_DIV;
            ppc_pkg::ST_DIV:    if (w_div.done) n_state = ppc_pkg::ST_EMA;
            ppc_pkg::ST_EMA:    n_state = r_seeded[w_ci] ? ppc_pkg::ST_AVG : ppc_pkg::ST_DONE;
            ppc_pkg::ST_AVG:    n_state = ppc_pkg::ST_POS;
            ppc_pkg::ST_POS:    n_state = ppc_pkg::ST_DONE;
            ppc_pkg::ST_DONE:   if (!r_out_valid || o_out.ready) n_state = ppc_pkg::ST_IDLE;
            default:            n_state = ppc_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: input ready, multiplier operands, divider start
    always_comb begin
        i_in.ready  = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_div_start = 1'b0;
        unique case (r_state)
            ppc_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
            end
            ppc_pkg::ST_SPAN: begin
                w_mul_a = ppc_pkg::MUL_W'(r_span);
                w_mul_b = ppc_pkg::MUL_W'(w_dz_sat);
            end
            ppc_pkg::ST_TRIM: begin
                w_mul_a = ppc_pkg::MUL_W'(w_prod[ppc_pkg::TRIM_IN_W-1:0]);
                w_mul_b = ppc_pkg::MUL_W'(ppc_pkg::RECIP_100);
            end
            ppc_pkg::ST_DIVGO: begin
                w_div_start = 1'b1;
            end
            ppc_pkg::ST_EMA: begin
                w_mul_a = ppc_pkg::MUL_W'(w_alpha);
                w_mul_b = ppc_pkg::MUL_W'(w_delta);
            end
            default: begin
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ppc_pkg::NCH_REGS; i++) begin
                r_low[i]  <= ppc_pkg::LOW_RESET;
                r_high[i] <= ppc_pkg::HIGH_RESET;
            end
            r_dz <= ppc_pkg::DZ_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                ppc_pkg::CFG_LOW_CH0:   r_low[0]  <= i_cfg.data;
                ppc_pkg::CFG_HIGH_CH0:  r_high[0] <= i_cfg.data;
                ppc_pkg::CFG_LOW_CH1:   r_low[1]  <= i_cfg.data;
                ppc_pkg::CFG_HIGH_CH1:  r_high[1] <= i_cfg.data;
                ppc_pkg::CFG_LOW_CH2:   r_low[2]  <= i_cfg.data;
                ppc_pkg::CFG_HIGH_CH2:  r_high[2] <= i_cfg.data;
                ppc_pkg::CFG_DEAD_ZONE: r_dz      <= i_cfg.data[ppc_pkg::DZ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Working registers along the sequence
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ppc_pkg::ST_IDLE: begin
                r_ch <= i_in.channel;
                r_mv <= i_in.sample_mv;
            end
            ppc_pkg::ST_LOOKUP: begin
                r_lo   <= w_lo;
                r_hi   <= w_hi;
                r_span <= w_hi - w_lo;
                r_res  <= '0;
            end
            ppc_pkg::ST_RANGE: begin
                r_rlo <= r_lo + w_trim;
                r_rhi <= r_hi - w_trim;
            end
            ppc_pkg::ST_CLAMP: begin
                r_rspan <= r_rhi - r_rlo;
                // 255 * offset
                r_num   <= (ppc_pkg::NUM_W'(w_off) << 8) - ppc_pkg::NUM_W'(w_off);
            end
            ppc_pkg::ST_DIV: begin
                if (w_div.done) begin
                    r_scaled <= (r_rspan == '0) ? '0 : w_div.quot;
                end
            end
            ppc_pkg::ST_EMA: begin
                r_res <= r_scaled;
            end
            ppc_pkg::ST_POS: begin
                r_res <= w_pos_new;
            end
            default: begin
            end
        endcase
    end

    // Per-channel state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ppc_pkg::CHANNELS; i++) begin
                r_seeded[i] <= 1'b0;
                r_avg[i]    <= '0;
                r_last[i]   <= '0;
            end
        end else begin
            if ((r_state == ppc_pkg::ST_EMA) && !r_seeded[w_ci]) begin
                // first sample seeds the channel
                r_seeded[w_ci] <= 1'b1;
                r_avg[w_ci]    <= {r_scaled, 8'b0};
                r_last[w_ci]   <= r_scaled;
            end else if (r_state == ppc_pkg::ST_AVG) begin
                r_avg[w_ci] <= w_avg_new;
            end else if (r_state == ppc_pkg::ST_POS) begin
                r_last[w_ci] <= w_pos_new;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ppc_pkg::ST_DONE) && (!r_out_valid || o_out.ready)) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ppc_pkg::ST_DONE) && (!r_out_valid || o_out.ready)) begin
            r_out_pos <= r_res;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.position = r_out_pos;

endmodule
